[rtl/core/pn_pkg.sv]
// Shared types, constants, the gradient function and the lerp step select function of the 3D fractal noise block.
`default_nettype none
package pn_pkg;

    localparam int PERM_SIZE   = 256;
    localparam int PERM_W      = $clog2(PERM_SIZE);
    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W       = $clog2(MAX_OCTAVES);

    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 25;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 40;
    localparam int SUM_W    = 20;
    localparam int DIV_CNT_W = $clog2(ACC_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_POS,
        ST_FADE,
        ST_HASH,
        ST_LERP,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        REG_OCTAVE_COUNT   = 2'd0,
        REG_COORD_SCALE    = 2'd1,
        REG_FREQUENCY_STEP = 2'd2,
        REG_AMPLITUDE_STEP = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [3:0]  octave_count;
        logic [23:0] coord_scale;
        logic [15:0] frequency_step;
        logic [15:0] amplitude_step;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [7:0]         table_index;
        logic [7:0]         table_value;
    } item_t;

    typedef struct packed {
        logic [2:0] m1;
        logic [2:0] m2;
        logic [2:0] dst;
        logic [1:0] tsel;
    } lerp_sel_t;

    function automatic logic signed [18:0] grad_dot(
        input logic [3:0]         h,
        input logic signed [17:0] x,
        input logic signed [17:0] y,
        input logic signed [17:0] z
    );
        logic signed [18:0] xe;
        logic signed [18:0] ye;
        logic signed [18:0] ze;
        logic signed [18:0] r;
        xe = {x[17], x};
        ye = {y[17], y};
        ze = {z[17], z};
        unique case (h)
            4'h0: r = xe + ye;
            4'h1: r = ye - xe;
            4'h2: r = xe - ye;
            4'h3: r = -xe - ye;
            4'h4: r = xe + ze;
            4'h5: r = ze - xe;
            4'h6: r = xe - ze;
            4'h7: r = -xe - ze;
            4'h8: r = ye + ze;
            4'h9: r = ze - ye;
            4'hA: r = ye - ze;
            4'hB: r = -ye - ze;
            4'hC: r = ye + xe;
            4'hD: r = ze - ye;
            4'hE: r = ye - xe;
            4'hF: r = -ye - ze;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic lerp_sel_t lerp_sel(input logic [2:0] step);
        lerp_sel_t s;
        unique case (step)
            3'd0: s = '{m1: 3'd0, m2: 3'd4, dst: 3'd0, tsel: 2'd0};
            3'd1: s = '{m1: 3'd2, m2: 3'd6, dst: 3'd2, tsel: 2'd0};
            3'd2: s = '{m1: 3'd1, m2: 3'd5, dst: 3'd1, tsel: 2'd0};
            3'd3: s = '{m1: 3'd3, m2: 3'd7, dst: 3'd3, tsel: 2'd0};
            3'd4: s = '{m1: 3'd0, m2: 3'd2, dst: 3'd0, tsel: 2'd1};
            3'd5: s = '{m1: 3'd1, m2: 3'd3, dst: 3'd1, tsel: 2'd1};
            default: s = '{m1: 3'd0, m2: 3'd1, dst: 3'd0, tsel: 2'd2};
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/core/perlin_noise_3d_octaves.sv]
// Top level: stream ports, configuration registers and output register.
// A table write transaction writes one permutation table entry and produces no result.
// A noise sample reaches m_axis_tvalid after the octave steps, the divider and the output register,
// and the next transaction is accepted once the result is taken: per octave the sequencer runs
// 52 steps, 24 of them chained table reads, and the divider then runs once per sample.
// One item is in work at a time; rst_n clears control and loads register defaults.
`default_nettype none
module perlin_noise_3d_octaves
    import pn_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [111:0] s_axis_tdata,  // coord_x, coord_y, coord_z, table_index, table_value
    input  wire logic [0:0]   s_axis_tuser,  // mode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [15:0]       m_axis_tdata,  // noise_value
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_wdata
);

    cfg_t        cfg_reg;
    item_t       item;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        res_valid;
    logic        res_ready;
    logic [15:0] res_value;

    assign item.mode        = s_axis_tuser[0];
    assign item.coord_x     = s_axis_tdata[31:0];
    assign item.coord_y     = s_axis_tdata[63:32];
    assign item.coord_z     = s_axis_tdata[95:64];
    assign item.table_index = s_axis_tdata[103:96];
    assign item.table_value = s_axis_tdata[111:104];

    assign res_ready = !out_valid_reg || m_axis_tready;

    pn_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .item      (item),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_value (res_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.octave_count   <= 4'd1;
            cfg_reg.coord_scale    <= 24'd65536;
            cfg_reg.frequency_step <= 16'd8192;
            cfg_reg.amplitude_step <= 16'd32768;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_OCTAVE_COUNT:   cfg_reg.octave_count   <= cfg_wdata[3:0];
                REG_COORD_SCALE:    cfg_reg.coord_scale    <= cfg_wdata;
                REG_FREQUENCY_STEP: cfg_reg.frequency_step <= cfg_wdata[15:0];
                REG_AMPLITUDE_STEP: cfg_reg.amplitude_step <= cfg_wdata[15:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

[rtl/core/pn_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none
module pn_mul
    import pn_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0]      p
);

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

[rtl/core/pn_div.sv]
// Bit-serial signed by unsigned divider, quotient rounded toward zero.
`default_nettype none
module pn_div
    import pn_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [ACC_W-1:0] dividend,
    input  wire logic [SUM_W-1:0]        divisor,
    output logic                         done,
    output logic signed [ACC_W-1:0]      quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [ACC_W-1:0]     q_reg;
    logic                 neg_reg;
    logic [SUM_W:0]       shifted;
    logic                 fits;

    assign shifted = {rem_reg, q_reg[ACC_W-1]};
    assign fits    = shifted >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(ACC_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[ACC_W-1];
            q_reg   <= dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? SUM_W'(shifted - {1'b0, divisor}) : shifted[SUM_W-1:0];
            q_reg   <= {q_reg[ACC_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule
`default_nettype wire

[rtl/core/pn_core.sv]
// Sequencer, permutation table and datapath registers of the noise evaluator.
`default_nettype none
module pn_core
    import pn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire item_t item,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       res_valid,
    input  wire logic  res_ready,
    output logic [15:0] res_value
);

    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] phase_reg, phase_next;
    logic [OCT_W-1:0] oct_reg, oct_next;
    logic [OCT_W-1:0] oct_last_reg;

    logic signed [31:0] coord_reg [3];
    logic [35:0]        s_reg [3];
    logic [23:0]        pos_reg [3];
    logic [35:0]        plo_reg;
    logic signed [23:0] fw_reg;
    logic signed [17:0] fade_reg [3];
    logic [PERM_W-1:0]  h_reg;
    logic [PERM_W-1:0]  rd_reg;
    logic signed [19:0] d_reg [8];
    logic signed [19:0] m1_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [23:0]        freq_reg;
    logic [16:0]        amp_reg;
    logic [15:0]        res_reg;

    logic [7:0] perm_mem [PERM_SIZE];

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic [PERM_W-1:0] ram_addr;
    logic              div_start;
    logic              div_done;
    logic signed [ACC_W-1:0] div_q;

    logic       in_fire;
    logic [1:0] phase_last;
    logic [4:0] step_last;
    logic [4:0] step_inc;
    logic [1:0] axis_pos;
    logic [1:0] axis_fade;
    logic [1:0] sub_fade;
    logic [2:0] corner;
    logic [1:0] level;
    lerp_sel_t  ls;
    logic [15:0] t_fade;
    logic signed [20:0] diff;
    logic [35:0] pos_sum;
    logic signed [23:0] fade_sh;
    logic signed [40:0] n_plus;
    logic signed [40:0] r_half;
    logic [27:0] freq_sh;
    logic [PERM_W-1:0] off;
    logic [PERM_W-1:0] prev;

    assign in_fire   = in_valid && in_ready;
    assign axis_pos  = step_reg[2:1];
    assign axis_fade = step_reg[3:2];
    assign sub_fade  = step_reg[1:0];
    assign corner    = step_reg[4:2];
    assign level     = step_reg[1:0];
    assign ls        = lerp_sel(step_reg[2:0]);
    assign t_fade    = pos_reg[axis_fade][15:0];
    assign diff      = {d_reg[ls.m2][19], d_reg[ls.m2]} - {m1_reg[19], m1_reg};
    assign pos_sum   = plo_reg + {prod[17:0], 18'd0};
    assign fade_sh   = prod[39:16];
    assign freq_sh   = prod[39:12];
    assign n_plus    = {div_q[ACC_W-1], div_q} + 41'sd65536;
    assign r_half    = n_plus >>> 1;

    pn_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    pn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        phase_last = (state_reg == ST_LERP) ? 2'd2 : 2'd1;
        step_inc   = (state_reg == ST_HASH && level == 2'd2) ?
                     {corner + 3'd1, 2'd0} : step_reg + 5'd1;
        unique case (state_reg)
            ST_SCALE: step_last = 5'd2;
            ST_POS:   step_last = 5'd5;
            ST_FADE:  step_last = 5'd11;
            ST_HASH:  step_last = {3'd7, 2'd2};
            ST_LERP:  step_last = 5'd6;
            ST_ACC:   step_last = 5'd2;
            default:  step_last = 5'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        oct_next   = oct_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && item.mode)
                begin
                    state_next = ST_SCALE;
                    step_next  = '0;
                    phase_next = '0;
                    oct_next   = '0;
                end
            end
            ST_SCALE, ST_POS, ST_FADE, ST_HASH, ST_LERP, ST_ACC:
            begin
                if (phase_reg != phase_last)
                begin
                    phase_next = phase_reg + 2'd1;
                end
                else
                begin
                    phase_next = '0;
                    if (step_reg != step_last)
                    begin
                        step_next = step_inc;
                    end
                    else
                    begin
                        step_next = '0;
                        unique case (state_reg)
                            ST_SCALE: state_next = ST_POS;
                            ST_POS:   state_next = ST_FADE;
                            ST_FADE:  state_next = ST_HASH;
                            ST_HASH:  state_next = ST_LERP;
                            ST_LERP:  state_next = ST_ACC;
                            default:
                            begin
                                if (oct_reg == oct_last_reg)
                                begin
                                    state_next = ST_DIV;
                                end
                                else
                                begin
                                    state_next = ST_POS;
                                    oct_next   = oct_reg + OCT_W'(1);
                                end
                            end
                        endcase
                    end
                end
            end
            ST_DIV:
            begin
                if (phase_reg == 2'd0)
                begin
                    phase_next = 2'd1;
                end
                else if (div_done)
                begin
                    phase_next = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        div_start = (state_reg == ST_DIV) && (phase_reg == 2'd0);
        mul_a     = '0;
        mul_b     = '0;
        unique case (level)
            2'd0:    off = PERM_W'(corner[2]);
            2'd1:    off = PERM_W'(corner[1]);
            default: off = PERM_W'(corner[0]);
        endcase
        prev     = (level == 2'd0) ? '0 : h_reg;
        ram_addr = prev + pos_reg[level][23:16] + off;
        unique case (state_reg)
            ST_SCALE:
            begin
                mul_a = {coord_reg[step_reg[1:0]][31], coord_reg[step_reg[1:0]]};
                mul_b = {1'b0, cfg.coord_scale};
            end
            ST_POS:
            begin
                mul_a = {15'd0, step_reg[0] ? s_reg[axis_pos][35:18] : s_reg[axis_pos][17:0]};
                mul_b = {1'b0, freq_reg};
            end
            ST_FADE:
            begin
                mul_b = {9'd0, t_fade};
                if (sub_fade == 2'd0)
                begin
                    mul_a = {15'd0, t_fade, 2'd0} + {16'd0, t_fade, 1'b0} - 33'sd983040;
                end
                else
                begin
                    mul_a = {{9{fw_reg[23]}}, fw_reg};
                end
            end
            ST_LERP:
            begin
                mul_a = {{12{diff[20]}}, diff};
                mul_b = {{7{fade_reg[ls.tsel][17]}}, fade_reg[ls.tsel]};
            end
            ST_ACC:
            begin
                unique case (step_reg[1:0])
                    2'd0:
                    begin
                        mul_a = {{13{d_reg[0][19]}}, d_reg[0]};
                        mul_b = {8'd0, amp_reg};
                    end
                    2'd1:
                    begin
                        mul_a = {9'd0, freq_reg};
                        mul_b = {9'd0, cfg.frequency_step};
                    end
                    default:
                    begin
                        mul_a = {16'd0, amp_reg};
                        mul_b = {9'd0, cfg.amplitude_step};
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            phase_reg <= '0;
            oct_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            oct_reg   <= oct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire && !item.mode)
        begin
            perm_mem[item.table_index] <= item.table_value;
        end
        rd_reg <= perm_mem[ram_addr][PERM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire)
        begin
            coord_reg[0] <= item.coord_x;
            coord_reg[1] <= item.coord_y;
            coord_reg[2] <= item.coord_z;
            acc_reg      <= '0;
            sum_reg      <= '0;
            freq_reg     <= 24'd4096;
            amp_reg      <= 17'd65536;
            if (cfg.octave_count == 4'd0)
            begin
                oct_last_reg <= '0;
            end
            else if (cfg.octave_count > 4'(MAX_OCTAVES))
            begin
                oct_last_reg <= OCT_W'(MAX_OCTAVES - 1);
            end
            else
            begin
                oct_last_reg <= OCT_W'(cfg.octave_count - 4'd1);
            end
        end
        if (phase_reg == 2'd1)
        begin
            unique case (state_reg)
                ST_SCALE:
                begin
                    s_reg[step_reg[1:0]] <= prod[51:16];
                end
                ST_POS:
                begin
                    if (!step_reg[0])
                    begin
                        plo_reg <= prod[35:0];
                    end
                    else
                    begin
                        pos_reg[axis_pos] <= pos_sum[35:12];
                    end
                end
                ST_FADE:
                begin
                    unique case (sub_fade)
                        2'd0:    fw_reg <= fade_sh + 24'sd655360;
                        2'd3:    fade_reg[axis_fade] <= fade_sh[17:0];
                        default: fw_reg <= fade_sh;
                    endcase
                end
                ST_HASH:
                begin
                    h_reg <= rd_reg;
                    if (level == 2'd2)
                    begin
                        d_reg[corner] <= 20'(grad_dot(rd_reg[3:0],
                            {{2{corner[2]}}, pos_reg[0][15:0]},
                            {{2{corner[1]}}, pos_reg[1][15:0]},
                            {{2{corner[0]}}, pos_reg[2][15:0]}));
                    end
                end
                ST_ACC:
                begin
                    unique case (step_reg[1:0])
                        2'd0:
                        begin
                            acc_reg <= acc_reg + prod[ACC_W-1:0];
                            sum_reg <= sum_reg + SUM_W'(amp_reg);
                        end
                        2'd1:
                        begin
                            freq_reg <= (|freq_sh[27:24]) ? 24'hFFFFFF : freq_sh[23:0];
                        end
                        default:
                        begin
                            amp_reg <= prod[32:16];
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_LERP && phase_reg == 2'd0)
        begin
            m1_reg <= d_reg[ls.m1];
        end
        if (state_reg == ST_LERP && phase_reg == 2'd2)
        begin
            d_reg[ls.dst] <= 20'({m1_reg[19], m1_reg} + prod[36:16]);
        end
        if (state_reg == ST_DIV && div_done)
        begin
            if (r_half < 0)
            begin
                res_reg <= 16'd0;
            end
            else if (r_half > 41'sd65535)
            begin
                res_reg <= 16'hFFFF;
            end
            else
            begin
                res_reg <= r_half[15:0];
            end
        end
    end

    assign res_value = res_reg;

endmodule
`default_nettype wire
